/* rtl/core/ispb_pkg.sv */
package ispb_pkg;

  // Framebuffer geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int XCW        = $clog2(MAX_WIDTH + 1);
  localparam int YCW        = $clog2(MAX_HEIGHT + 1);

  // Signed working width for coordinate arithmetic
  localparam int CW = 18;
  typedef logic signed [CW-1:0] coord_t;

  // Written-pixel counter
  localparam int          CNT_W   = 18;
  localparam logic [17:0] CNT_MAX = 18'h3FFFF;

  // Command codes
  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_DRAW = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;
  localparam logic [9:0] SURFACE_WIDTH_RST  = 10'd320;
  localparam logic [8:0] SURFACE_HEIGHT_RST = 9'd200;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rect_end_x;
    logic signed [15:0] rect_end_y;
    logic [7:0]         color;
    logic [9:0]         sprite_col;
    logic [9:0]         sprite_row;
    logic [10:0]        sprite_width;
    logic [10:0]        sprite_height;
    logic [2:0]         draw_mode;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       pixel_value;
    logic             off_surface;
    logic [CNT_W-1:0] pixels_written;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic prep;
    logic plan;
    logic mem_re;
    logic mem_we;
    logic fill_adv;
    logic clear_we;
    logic load_out;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       draw_ok;
    logic       fill_nonempty;
    logic       fill_last;
    logic       clear_last;
  } sts_t;

endpackage

/* rtl/core/ispb_frame_ram.sv */
module ispb_frame_ram
  import ispb_pkg::*;
(
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Single port: write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ispb_datapath.sv */
module ispb_datapath
  import ispb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  ctl_t      ctl_i,
  input  logic [9:0] surface_width_i,
  input  logic [8:0] surface_height_i,
  output sts_t      sts_o,
  output out_word_t out_data_o
);

  localparam coord_t MAXW_S = coord_t'(MAX_WIDTH);
  localparam coord_t MAXH_S = coord_t'(MAX_HEIGHT);

  function automatic coord_t clamp_to(coord_t v, coord_t size);
    coord_t r;
    if (v < 0) begin
      r = '0;
    end else if (v < size) begin
      r = v;
    end else begin
      r = size;
    end
    return r;
  endfunction

  in_word_t        in_q;
  logic            oor_q;
  logic            in_sprite_q;
  logic [10:0]     dc_q, dr_q;
  logic [XCW-1:0]  x1_q, x2_q;
  logic [YCW-1:0]  y1_q, y2_q;
  logic            draw_ok_q;
  logic            nonempty_q;
  logic [XCW-1:0]  span_x_q;
  logic [YCW-1:0]  span_y_q;
  logic [XW-1:0]   cur_x_q;
  logic [YW-1:0]   cur_y_q;
  logic [CNT_W-1:0] count_q;
  logic [AW-1:0]   clr_q;
  out_word_t       out_q;

  coord_t eff_w, eff_h, reg_w, reg_h;
  coord_t px, py, ex, ey;
  coord_t cx1, cy1, cx2, cy2;
  coord_t draw_x, draw_y;
  logic   [XCW+YCW-1:0] prod;
  logic   x_wrap, y_wrap;
  logic   [AW-1:0] pix_addr, mem_addr;
  logic   [7:0]    rdata;
  logic   is_read, is_fill, is_draw;

  // Limit the surface registers to the store's geometry
  assign reg_w = coord_t'(signed'({1'b0, surface_width_i}));
  assign reg_h = coord_t'(signed'({1'b0, surface_height_i}));
  assign eff_w = (reg_w > MAXW_S) ? MAXW_S : reg_w;
  assign eff_h = (reg_h > MAXH_S) ? MAXH_S : reg_h;

  assign px = coord_t'(in_q.pos_x);
  assign py = coord_t'(in_q.pos_y);
  assign ex = coord_t'(in_q.rect_end_x);
  assign ey = coord_t'(in_q.rect_end_y);
  assign cx1 = clamp_to(px, eff_w);
  assign cy1 = clamp_to(py, eff_h);
  assign cx2 = clamp_to(ex, eff_w);
  assign cy2 = clamp_to(ey, eff_h);

  assign is_read = (in_q.command == CMD_READ);
  assign is_fill = (in_q.command == CMD_FILL);
  assign is_draw = (in_q.command == CMD_DRAW);

  // Hold the accepted word
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // Step one: range test, clamping and mirroring
  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      oor_q       <= (px < 0) || (py < 0) || (px >= eff_w) || (py >= eff_h);
      x1_q        <= XCW'(cx1);
      y1_q        <= YCW'(cy1);
      x2_q        <= XCW'(cx2);
      y2_q        <= YCW'(cy2);
      in_sprite_q <= ({1'b0, in_q.sprite_col} < in_q.sprite_width) &&
                     ({1'b0, in_q.sprite_row} < in_q.sprite_height);
      dc_q <= in_q.draw_mode[0] ? (in_q.sprite_width - 11'd1 - {1'b0, in_q.sprite_col})
                                : {1'b0, in_q.sprite_col};
      dr_q <= in_q.draw_mode[1] ? (in_q.sprite_height - 11'd1 - {1'b0, in_q.sprite_row})
                                : {1'b0, in_q.sprite_row};
    end
  end

  // Step two: place the sprite pixel, size the rectangle
  assign draw_x = px + coord_t'(signed'({1'b0, dc_q}));
  assign draw_y = py + coord_t'(signed'({1'b0, dr_q}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.plan) begin
      draw_ok_q <= in_sprite_q && (draw_x >= 0) && (draw_y >= 0) &&
                   (draw_x < eff_w) && (draw_y < eff_h) &&
                   ((in_q.color != 8'd0) || in_q.draw_mode[2]);
      nonempty_q <= (x2_q > x1_q) && (y2_q > y1_q);
      if ((x2_q > x1_q) && (y2_q > y1_q)) begin
        span_x_q <= x2_q - x1_q;
        span_y_q <= y2_q - y1_q;
      end else begin
        span_x_q <= '0;
        span_y_q <= '0;
      end
    end
  end

  // Count the rectangle, saturating
  assign prod = (XCW+YCW)'(span_x_q) * (XCW+YCW)'(span_y_q);

  always_ff @(posedge clk_i) begin
    if (32'(prod) > 32'(CNT_MAX)) begin
      count_q <= CNT_MAX;
    end else begin
      count_q <= CNT_W'(prod);
    end
  end

  // Pixel cursor: load in step two, advance along rows while filling
  assign x_wrap = ((XCW'(cur_x_q) + XCW'(1)) == x2_q);
  assign y_wrap = ((YCW'(cur_y_q) + YCW'(1)) == y2_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.plan) begin
      if (is_fill) begin
        cur_x_q <= XW'(x1_q);
        cur_y_q <= YW'(y1_q);
      end else if (is_draw) begin
        cur_x_q <= XW'(draw_x);
        cur_y_q <= YW'(draw_y);
      end else begin
        cur_x_q <= XW'(px);
        cur_y_q <= YW'(py);
      end
    end else if (ctl_i.fill_adv) begin
      if (x_wrap) begin
        cur_x_q <= XW'(x1_q);
        cur_y_q <= cur_y_q + YW'(1);
      end else begin
        cur_x_q <= cur_x_q + XW'(1);
      end
    end
  end

  // Sweep the store to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clear_we) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign pix_addr = AW'(cur_y_q) * AW'(MAX_WIDTH) + AW'(cur_x_q);
  assign mem_addr = ctl_i.clear_we ? clr_q : pix_addr;

  ispb_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.mem_we | ctl_i.clear_we),
    .re_i    (ctl_i.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (ctl_i.clear_we ? 8'd0 : in_q.color),
    .rdata_o (rdata)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_q.pixel_value <= (is_read && !oor_q) ? rdata : 8'd0;
      out_q.off_surface <= is_read && oor_q;
      if (is_fill) begin
        out_q.pixels_written <= count_q;
      end else if (is_draw) begin
        out_q.pixels_written <= CNT_W'(draw_ok_q);
      end else begin
        out_q.pixels_written <= '0;
      end
    end
  end

  assign out_data_o = out_q;

  assign sts_o.cmd           = in_q.command;
  assign sts_o.draw_ok       = draw_ok_q;
  assign sts_o.fill_nonempty = nonempty_q;
  assign sts_o.fill_last     = x_wrap && y_wrap;
  assign sts_o.clear_last    = (clr_q == AW'(DEPTH - 1));

endmodule

/* rtl/core/ispb_ctrl.sv */
module ispb_ctrl
  import ispb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_PLAN,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequence one word through the datapath
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctl_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clear_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        ctl_o.prep = 1'b1;
        state_d    = ST_PLAN;
      end
      ST_PLAN: begin
        ctl_o.plan = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (sts_i.cmd)
          CMD_READ: begin
            ctl_o.mem_re = 1'b1;
          end
          CMD_DRAW: begin
            ctl_o.mem_we = sts_i.draw_ok;
          end
          CMD_FILL: begin
            if (sts_i.fill_nonempty) begin
              ctl_o.mem_we   = 1'b1;
              ctl_o.fill_adv = 1'b1;
              if (!sts_i.fill_last) begin
                state_d = ST_FILL;
              end
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_FILL: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.fill_adv = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the result once the output slot is free
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/indexed_sprite_blitter.sv */
// Indexed sprite blitter: an 8-bit indexed framebuffer of MAX_WIDTH x MAX_HEIGHT pixels
// (512 x 256) with read, fill-rectangle and draw-sprite-pixel commands. After reset the
// block sweeps the whole store to zero, one pixel per cycle, and keeps in_stall_o high
// meanwhile; the configuration port works during the sweep. A read or a draw word then
// passes through the prepare, plan and execute states; its result is loaded into the
// output register in the done state, after which the next word can be accepted. A fill
// writes its pixels one per cycle in the execute and fill states, none when the clamped
// rectangle is empty. A finished word waits, and the block stays busy, for as long as
// an earlier result is still stalled in the output register. The sequence follows from
// the single-port frame memory, which takes one pixel per cycle, and the three-step
// coordinate pipeline (clamp and mirror, place, access). One word is in flight at a
// time; a finished result waits in the output register while the next word is accepted.
module indexed_sprite_blitter
  import ispb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0] surface_width_q;
  logic [8:0] surface_height_q;
  ctl_t       ctl;
  sts_t       sts;
  logic       cfg_we;

  // Configuration registers
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surface_width_q  <= SURFACE_WIDTH_RST;
      surface_height_q <= SURFACE_HEIGHT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_IDX_WIDTH) begin
        surface_width_q <= pwdata[9:0];
      end else begin
        surface_height_q <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IDX_HEIGHT) begin
      prdata = {23'd0, surface_height_q};
    end else begin
      prdata = {22'd0, surface_width_q};
    end
  end

  ispb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  ispb_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_data_i        (in_data_i),
    .ctl_i            (ctl),
    .surface_width_i  (surface_width_q),
    .surface_height_i (surface_height_q),
    .sts_o            (sts),
    .out_data_o       (out_data_o)
  );

  // Accepting a word makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a word without going busy");

  // Frame writes come only from fill or draw words, or from the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.mem_we |-> !ctl.clear_we && (sts.cmd == CMD_FILL || sts.cmd == CMD_DRAW))
    else $error("frame write outside a fill or draw");

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> !out_valid_o || !out_stall_i)
    else $error("pending result overwritten");

  // An out-of-range read carries no pixel and no write count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.off_surface |->
      out_data_o.pixel_value == 8'd0 && out_data_o.pixels_written == '0)
    else $error("out-of-range read with data");

endmodule
